@@ sv/rlbc_pkg.sv @@
package rlbc_pkg;

  localparam int unsigned AddrW  = 48;
  localparam int unsigned SizeW  = 40;
  localparam int unsigned CapW   = 46;
  localparam int unsigned CountW = 16;
  localparam int unsigned FactW  = 5;
  localparam int unsigned StatW  = 3;
  localparam int unsigned MaxResults = 32;

  localparam logic [1:0] OpInsert  = 2'd0;
  localparam logic [1:0] OpAcquire = 2'd1;
  localparam logic [1:0] OpRelease = 2'd2;
  localparam logic [1:0] OpEvict   = 2'd3;

  localparam logic [StatW-1:0] StOk        = 3'd0;
  localparam logic [StatW-1:0] StNotFound  = 3'd1;
  localparam logic [StatW-1:0] StNoSlot    = 3'd2;
  localparam logic [StatW-1:0] StDuplicate = 3'd3;
  localparam logic [StatW-1:0] StUnderflow = 3'd4;
  localparam logic [StatW-1:0] StNoEvict   = 3'd5;

  localparam logic RegCapacity = 1'b0;
  localparam logic RegFactor   = 1'b1;

  typedef struct packed {
    logic [1:0]       operation;
    logic [AddrW-1:0] address;
    logic [SizeW-1:0] size;
    logic             is_write;
  } req_t;

  typedef struct packed {
    logic [StatW-1:0]  status;
    logic [CountW-1:0] use_count;
    logic              full_flag;
    logic [AddrW-1:0]  evicted_address;
    logic [SizeW-1:0]  evicted_size;
    logic              needs_writeback;
    logic              fits_request;
    logic              reuse_valid;
    logic [AddrW-1:0]  reuse_address;
    logic              last;
  } result_t;

  // one cached block as held in a cell
  typedef struct packed {
    logic              valid;
    logic [AddrW-1:0]  key;
    logic [SizeW-1:0]  size;
    logic              dirty;
    logic [CountW-1:0] refs;
  } entry_t;

  // command from the sequencer to every cell
  typedef struct packed {
    logic       shift;     // compact: cells at or above sel take their upper neighbour
    logic       insert;    // first free cell loads new block
    logic       ref_inc;
    logic       ref_dec;
    logic       move_mru;  // selected block rotated to the top
  } cell_cmd_t;

endpackage

@@ sv/rlbc_cell.sv @@
// one slot of the LRU row; lower index is older
module rlbc_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  rlbc_pkg::cell_cmd_t  cmd,
  input  logic                 at_sel,     // this cell is the selected one
  input  logic                 above_sel,  // this cell is above the selected one
  input  logic                 is_top,     // last valid (or first free) target
  input  rlbc_pkg::entry_t     upper,      // neighbour toward MRU
  input  rlbc_pkg::entry_t     sel_entry,  // selected block, for move to MRU
  input  rlbc_pkg::entry_t     new_entry,
  output rlbc_pkg::entry_t     ent
);

  rlbc_pkg::entry_t upd;

  always_comb begin
    upd = sel_entry;
    if (cmd.ref_inc && upd.refs != '1) upd.refs = upd.refs + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
    end else if (cmd.insert && is_top) begin
      ent <= new_entry;
    end else if (cmd.ref_dec && at_sel) begin
      ent.refs <= ent.refs - 1'b1;
    end else if (cmd.move_mru && is_top) begin
      ent <= upd;
    end else if ((cmd.shift || cmd.move_mru) && (at_sel || above_sel)) begin
      ent <= upper;
    end
  end

endmodule

@@ sv/refcounted_lru_block_cache_unit.sv @@
// LRU cache of device blocks with use counts. Blocks sit in a row of cells
// ordered from LRU (cell 0) to MRU; a valid cell is always below every free
// cell. Insert, acquire and release register the request, then do the
// associative match over all cells, then update the row and form the single
// result. Evict walks the row from the LRU end, one cell per cycle; a freed
// block is formed as a result and the row above it is compacted in the same
// cycle, so the same cell is looked at again. When nothing is freed, a
// further state forms a no-evict result. The walk stops once the target is
// met, the result limit is hit or no freeable block is left further up the
// row. A new request is taken only after the walk ends. Each result is
// registered on its way to the ports and stays for exactly one cycle with
// result_valid high; the receiver cannot stall. busy is high while a request
// is worked on, up to the cycle in which the last result is formed.
module refcounted_lru_block_cache_unit #(
  parameter int unsigned ENTRIES = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  rlbc_pkg::req_t                       req,
  output logic                                 result_valid,
  output rlbc_pkg::result_t                    result,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic                                 cfg_index,
  input  logic [rlbc_pkg::CapW-1:0]            cfg_data
);

  localparam int unsigned IdxW = $clog2(ENTRIES);
  localparam int unsigned CntW = $clog2(ENTRIES + 1);
  localparam int unsigned ResW = $clog2(rlbc_pkg::MaxResults + 1);
  localparam int unsigned TgtW = rlbc_pkg::SizeW + rlbc_pkg::FactW;
  localparam int unsigned FreW = rlbc_pkg::SizeW + ResW;

  typedef enum logic [2:0] {S_IDLE, S_MATCH, S_APPLY, S_WALK, S_NONE} state_t;

  state_t                       state;
  rlbc_pkg::req_t               rq;
  logic [rlbc_pkg::CapW-1:0]    capacity;
  logic [rlbc_pkg::FactW-1:0]   free_factor;
  logic [rlbc_pkg::CapW-1:0]    bytes_used;
  logic                         full;
  logic [TgtW-1:0]              target;
  logic [FreW-1:0]              freed;
  logic [ResW-1:0]              nres;
  logic [IdxW-1:0]              pos;
  logic [IdxW-1:0]              sel;
  logic                         hit;
  logic [CntW-1:0]              live;
  logic                         reuse;
  logic [rlbc_pkg::AddrW-1:0]   reuse_addr;
  rlbc_pkg::cell_cmd_t          cmd;
  rlbc_pkg::entry_t             ents [ENTRIES];
  rlbc_pkg::entry_t             uppers [ENTRIES];
  rlbc_pkg::entry_t             new_entry;
  rlbc_pkg::entry_t             sel_entry;
  rlbc_pkg::result_t            res_next;
  logic                         emit;
  logic [ENTRIES-1:0]           match_vec;
  logic [IdxW-1:0]              match_idx;
  logic [IdxW-1:0]              csel;
  logic [IdxW-1:0]              top_idx;
  logic [FreW-1:0]              freed_next;
  logic                         walk_free;
  logic                         walk_end;
  logic                         more_free;

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);

  // associative match and live count
  always_comb begin
    match_vec = '0;
    match_idx = '0;
    live = '0;
    for (int k = 0; k < ENTRIES; k++) begin
      match_vec[k] = ents[k].valid && ents[k].key == rq.address;
      if (match_vec[k]) match_idx = IdxW'(k);
      live = live + CntW'(ents[k].valid);
    end
  end

  assign sel_entry = ents[sel];
  assign new_entry = '{valid: 1'b1, key: rq.address, size: rq.size,
                       dirty: rq.is_write, refs: rlbc_pkg::CountW'(1)};

  // cells take the walk position as their select while walking
  assign csel = (state == S_WALK) ? pos : sel;

  // insert targets the first free cell; move to MRU targets the last valid
  always_comb begin
    if (cmd.insert) top_idx = IdxW'(live);
    else            top_idx = IdxW'(live - 1'b1);
  end

  always_comb begin
    for (int k = 0; k < ENTRIES; k++) begin
      if (k == ENTRIES - 1) uppers[k] = '0;
      else                  uppers[k] = ents[k + 1];
    end
  end

  genvar g;
  generate
    for (g = 0; g < ENTRIES; g++) begin : g_cell
      rlbc_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .cmd       (cmd),
        .at_sel    (csel == IdxW'(g)),
        .above_sel (IdxW'(g) > csel),
        .is_top    (top_idx == IdxW'(g)),
        .upper     (uppers[g]),
        .sel_entry (sel_entry),
        .new_entry (new_entry),
        .ent       (ents[g])
      );
    end
  endgenerate

  // any freeable block beyond the walk position
  always_comb begin
    more_free = 1'b0;
    for (int k = 0; k < ENTRIES; k++)
      if (k > int'(pos) && ents[k].valid && ents[k].refs == '0) more_free = 1'b1;
  end

  // walk step: cell at pos, the row compacts so pos stays when a block goes
  assign walk_free  = ents[pos].valid && ents[pos].refs == '0;
  assign freed_next = freed + FreW'(ents[pos].size);

  always_comb begin
    cmd = '0;
    emit = 1'b0;
    walk_end = 1'b0;
    res_next = '0;
    res_next.full_flag = full;
    res_next.last = 1'b1;
    case (state)
      S_APPLY: begin
        emit = 1'b1;
        case (rq.operation)
          rlbc_pkg::OpInsert: begin
            if (hit) res_next.status = rlbc_pkg::StDuplicate;
            else if (live == CntW'(ENTRIES)) res_next.status = rlbc_pkg::StNoSlot;
            else cmd.insert = 1'b1;
          end
          rlbc_pkg::OpAcquire: begin
            if (!hit) res_next.status = rlbc_pkg::StNotFound;
            else begin
              cmd.move_mru = 1'b1;
              cmd.ref_inc = 1'b1;
              res_next.use_count = (sel_entry.refs == '1) ? sel_entry.refs
                                                          : sel_entry.refs + 1'b1;
            end
          end
          default: begin
            if (!hit) res_next.status = rlbc_pkg::StNotFound;
            else if (sel_entry.refs == '0) res_next.status = rlbc_pkg::StUnderflow;
            else begin
              cmd.ref_dec = 1'b1;
              res_next.use_count = sel_entry.refs - 1'b1;
            end
          end
        endcase
      end
      S_WALK: begin
        if (!ents[pos].valid) walk_end = 1'b1;
        else if (walk_free) begin
          emit = 1'b1;
          cmd.shift = 1'b1;
          res_next.evicted_address = ents[pos].key;
          res_next.evicted_size = ents[pos].size;
          res_next.needs_writeback = ents[pos].dirty;
          res_next.fits_request = ents[pos].size >= rq.size;
          // last result once the target is met, the limit is hit or nothing
          // freeable is left further up the row
          walk_end = (FreW'(target) <= freed_next) ||
                     (nres == ResW'(rlbc_pkg::MaxResults - 1)) || !more_free;
          res_next.last = walk_end;
          res_next.reuse_valid = walk_end && (reuse || res_next.fits_request);
          res_next.reuse_address = !walk_end ? '0 :
                                   res_next.fits_request ? ents[pos].key : reuse_addr;
        end else begin
          walk_end = (pos == IdxW'(ENTRIES - 1));
        end
      end
      S_NONE: begin
        emit = 1'b1;
        res_next.status = rlbc_pkg::StNoEvict;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      result_valid <= 1'b0;
      capacity <= '0;
      free_factor <= rlbc_pkg::FactW'(2);
      bytes_used <= '0;
    end else begin
      result_valid <= emit;
      result <= res_next;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == rlbc_pkg::RegCapacity) capacity <= cfg_data;
        else free_factor <= cfg_data[rlbc_pkg::FactW-1:0];
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            rq <= req;
            state <= S_MATCH;
          end
        end
        S_MATCH: begin
          full <= ({1'b0, bytes_used} + (rlbc_pkg::CapW+1)'(rq.size)) >= {1'b0, capacity};
          target <= rq.size * free_factor;
          hit <= |match_vec;
          sel <= match_idx;
          pos <= '0;
          nres <= '0;
          freed <= '0;
          reuse <= 1'b0;
          reuse_addr <= '0;
          state <= (rq.operation == rlbc_pkg::OpEvict) ? S_WALK : S_APPLY;
        end
        S_APPLY: begin
          if (cmd.insert) begin
            if ({1'b0, bytes_used} + (rlbc_pkg::CapW+1)'(rq.size) > {1'b0, {rlbc_pkg::CapW{1'b1}}})
              bytes_used <= '1;
            else
              bytes_used <= bytes_used + rlbc_pkg::CapW'(rq.size);
          end
          state <= S_IDLE;
        end
        S_WALK: begin
          if (walk_free) begin
            nres <= nres + 1'b1;
            freed <= freed_next;
            if (res_next.fits_request) begin
              reuse <= 1'b1;
              reuse_addr <= ents[pos].key;
            end
          end else if (!walk_end) begin
            pos <= pos + 1'b1;
          end
          if (walk_end) begin
            if (walk_free || nres != '0) begin
              if ((rlbc_pkg::CapW+1)'(walk_free ? freed_next : freed) > {1'b0, bytes_used})
                bytes_used <= '0;
              else
                bytes_used <= bytes_used - rlbc_pkg::CapW'(walk_free ? freed_next : freed);
              state <= S_IDLE;
            end else begin
              state <= S_NONE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_result_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy)) else $error("result without request");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("request not taken");
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.last) |-> !busy) else $error("busy after last result");
`endif

endmodule
